[rtl/core/irsc_pkg.sv]
// shared types and constants for the min/max and sortedness checker
`timescale 1ns / 1ps

package irsc_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [DATA_W-1:0]        count_t;

  localparam sample_t MISS_MARK = {1'b1, {(DATA_W-1){1'b0}}};
  localparam count_t  COUNT_MAX = {DATA_W{1'b1}};

  typedef enum logic {
    KIND_KEPT    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t   kind;
    sample_t kept_value;
    sample_t min_value;
    sample_t max_value;
    count_t  missing_count;
    logic    out_of_order;
    logic    run_end;
  } result_t;

endpackage

[rtl/core/irsc_if.sv]
// channel interfaces: input samples, results and configuration writes
`timescale 1ns / 1ps

interface irsc_in_if;
  import irsc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    final_item;
  modport source (output valid, output sample, output final_item, input ready);
  modport sink   (input valid, input sample, input final_item, output ready);
endinterface

interface irsc_out_if;
  import irsc_pkg::*;
  logic    valid;
  logic    ready;
  kind_t   kind;
  sample_t kept_value;
  sample_t min_value;
  sample_t max_value;
  count_t  missing_count;
  logic    out_of_order;
  logic    run_end;
  modport source (output valid, output kind, output kept_value, output min_value,
                  output max_value, output missing_count, output out_of_order,
                  output run_end, input ready);
  modport sink   (input valid, input kind, input kept_value, input min_value,
                  input max_value, input missing_count, input out_of_order,
                  input run_end, output ready);
endinterface

interface irsc_cfg_if;
  logic valid;
  logic ready;
  logic descending_order;
  modport source (output valid, output descending_order, input ready);
  modport sink   (input valid, input descending_order, output ready);
endinterface

[rtl/core/int_range_sortcheck_compact_top.sv]
// top level: streaming min/max, missing count, order check and compaction
//
// in_ch carries one signed sample and a final_item flag per item. a sample
// equal to the missing marker is dropped and counted; any other sample is
// passed out as a kept item. the item flagged final_item closes the stream:
// after its kept item, if any, a summary item follows with min, max,
// saturating missing count and the order flag, and all stream state clears.
// cfg_ch writes descending_order (always ready); write it while idle.
// results go through a four-entry output queue and leave it in order; a
// summary that follows a kept item of the same input comes straight after
// it. one item is accepted per cycle while the queue holds at most two
// results, so with an open receiver the rate is one item per cycle while the
// queue keeps that room; a final item with a kept value puts two results
// into the queue, which drain one per cycle. when the receiver stalls, the
// queue fills and in_ch.ready drops until two results fit again.
// rst_n (synchronous, active low) empties the queue, clears stream state
// and sets descending_order to 0.
`timescale 1ns / 1ps

module int_range_sortcheck_compact_top (
  input  logic       clk,
  input  logic       rst_n,
  irsc_in_if.sink    in_ch,
  irsc_cfg_if.sink   cfg_ch,
  irsc_out_if.source out_ch
);
  import irsc_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);

  logic    desc_r;
  logic    seen_r, seen_nxt;
  sample_t min_r, min_nxt;
  sample_t max_r, max_nxt;
  sample_t prev_r, prev_nxt;
  count_t  miss_r, miss_nxt;
  logic    broken_r, broken_nxt;

  result_t            queue_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]     cnt_r;

  logic    accept, pop, kept;
  logic [1:0] n_push;
  result_t kept_res, sum_res;

  assign in_ch.ready  = (cnt_r <= (PTR_W+1)'(QDEPTH - 2));
  assign cfg_ch.ready = 1'b1;
  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;
  assign kept   = (in_ch.sample != MISS_MARK);

  always_comb begin
    seen_nxt   = seen_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    prev_nxt   = prev_r;
    miss_nxt   = miss_r;
    broken_nxt = broken_r;
    if (!kept) begin
      if (miss_r != COUNT_MAX) begin
        miss_nxt = miss_r + count_t'(1);
      end
    end else begin
      if (!seen_r) begin
        min_nxt = in_ch.sample;
        max_nxt = in_ch.sample;
      end else begin
        if (in_ch.sample < min_r) begin
          min_nxt = in_ch.sample;
        end else if (max_r < in_ch.sample) begin
          max_nxt = in_ch.sample;
        end
        // equal neighbours never break the order
        if (desc_r ? (prev_r < in_ch.sample) : (in_ch.sample < prev_r)) begin
          broken_nxt = 1'b1;
        end
      end
      prev_nxt = in_ch.sample;
      seen_nxt = 1'b1;
    end
  end

  always_comb begin
    kept_res               = '0;
    kept_res.kind          = KIND_KEPT;
    kept_res.kept_value    = in_ch.sample;
    kept_res.run_end       = !in_ch.final_item;
    sum_res                = '0;
    sum_res.kind           = KIND_SUMMARY;
    sum_res.min_value      = min_nxt;
    sum_res.max_value      = max_nxt;
    sum_res.missing_count  = miss_nxt;
    sum_res.out_of_order   = broken_nxt;
    sum_res.run_end        = 1'b1;
    n_push = 2'(kept) + 2'(in_ch.final_item);
    if (!accept) begin
      n_push = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r   <= 1'b0;
      seen_r   <= 1'b0;
      min_r    <= MISS_MARK;
      max_r    <= MISS_MARK;
      prev_r   <= '0;
      miss_r   <= '0;
      broken_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_ch.valid) begin
        desc_r <= cfg_ch.descending_order;
      end
      if (accept) begin
        if (in_ch.final_item) begin
          // summary closes the stream
          seen_r   <= 1'b0;
          min_r    <= MISS_MARK;
          max_r    <= MISS_MARK;
          prev_r   <= '0;
          miss_r   <= '0;
          broken_r <= 1'b0;
        end else begin
          seen_r   <= seen_nxt;
          min_r    <= min_nxt;
          max_r    <= max_nxt;
          prev_r   <= prev_nxt;
          miss_r   <= miss_nxt;
          broken_r <= broken_nxt;
        end
      end
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop);
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      if (kept) begin
        queue_r[wr_ptr_r] <= kept_res;
      end
      if (in_ch.final_item) begin
        queue_r[wr_ptr_r + PTR_W'(kept)] <= sum_res;
      end
    end
  end

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.kind          = queue_r[rd_ptr_r].kind;
  assign out_ch.kept_value    = queue_r[rd_ptr_r].kept_value;
  assign out_ch.min_value     = queue_r[rd_ptr_r].min_value;
  assign out_ch.max_value     = queue_r[rd_ptr_r].max_value;
  assign out_ch.missing_count = queue_r[rd_ptr_r].missing_count;
  assign out_ch.out_of_order  = queue_r[rd_ptr_r].out_of_order;
  assign out_ch.run_end       = queue_r[rd_ptr_r].run_end;

endmodule

[bench/irsc_stream_watch.sv]
// checker: follows the channels, predicts every result and compares it on arrival
`timescale 1ns / 1ps

module irsc_stream_watch
  import irsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_ready,
  input  sample_t in_sample,
  input  logic    in_final,
  input  logic    cfg_valid,
  input  logic    cfg_ready,
  input  logic    cfg_descending,
  input  logic    out_valid,
  input  logic    out_ready,
  input  kind_t   out_kind,
  input  sample_t out_kept_value,
  input  sample_t out_min_value,
  input  sample_t out_max_value,
  input  count_t  out_missing_count,
  input  logic    out_out_of_order,
  input  logic    out_run_end,
  output int      fail_total,
  output int      due_count
);

  // own copy of the stream state and the order register
  logic    have_kept;
  sample_t lo_seen;
  sample_t hi_seen;
  sample_t last_kept;
  count_t  miss_cnt;
  logic    unsorted;
  logic    order_down;

  result_t due_results[$];
  int      errs = 0;

  task automatic clear_stream_state();
    have_kept = 1'b0;
    lo_seen   = MISS_MARK;
    hi_seen   = MISS_MARK;
    last_kept = '0;
    miss_cnt  = '0;
    unsorted  = 1'b0;
  endtask

  // fold one accepted sample into the state and queue the results it causes
  task automatic fold_sample(input sample_t s, input logic fin);
    result_t r;
    if (s == MISS_MARK) begin
      if (miss_cnt != COUNT_MAX) miss_cnt = miss_cnt + count_t'(1);
    end else begin
      if (!have_kept) begin
        lo_seen = s;
        hi_seen = s;
      end else begin
        if (s < lo_seen) lo_seen = s;
        else if (hi_seen < s) hi_seen = s;
        if (order_down) begin
          if (last_kept < s) unsorted = 1'b1;
        end else begin
          if (s < last_kept) unsorted = 1'b1;
        end
      end
      last_kept = s;
      have_kept = 1'b1;
      r = '0;
      r.kind       = KIND_KEPT;
      r.kept_value = s;
      r.run_end    = !fin;
      due_results.push_back(r);
    end
    if (fin) begin
      r = '0;
      r.kind          = KIND_SUMMARY;
      r.min_value     = lo_seen;
      r.max_value     = hi_seen;
      r.missing_count = miss_cnt;
      r.out_of_order  = unsorted;
      r.run_end       = 1'b1;
      due_results.push_back(r);
      clear_stream_state();
    end
  endtask

  task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
    errs++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_stream_state();
      order_down = 1'b0;
      due_results.delete();
    end else begin
      // results are registered before they can leave, so compare first
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none, actual kind %0d value %h",
                   $time, out_kind, out_kept_value);
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind) flag("kind", 32'(want.kind), 32'(out_kind));
          if (out_kept_value !== want.kept_value)
            flag("kept_value", want.kept_value, out_kept_value);
          if (out_min_value !== want.min_value) flag("min_value", want.min_value, out_min_value);
          if (out_max_value !== want.max_value) flag("max_value", want.max_value, out_max_value);
          if (out_missing_count !== want.missing_count)
            flag("missing_count", want.missing_count, out_missing_count);
          if (out_out_of_order !== want.out_of_order)
            flag("out_of_order", 32'(want.out_of_order), 32'(out_out_of_order));
          if (out_run_end !== want.run_end)
            flag("run_end", 32'(want.run_end), 32'(out_run_end));
        end
      end
      if (in_valid && in_ready) fold_sample(in_sample, in_final);
      if (cfg_valid && cfg_ready) order_down = cfg_descending;
    end
    fail_total <= errs;
    due_count  <= due_results.size();
  end

endmodule

[bench/tb_top.sv]
// testbench top: drives samples, order writes and receiver stalls, and gives the verdict
`timescale 1ns / 1ps

module tb_top;
  import irsc_pkg::*;

  localparam int      CYCLE_LIMIT = 900000;
  localparam sample_t TOP_VAL     = 32'sh7fffffff;
  localparam sample_t LOW_VAL     = 32'sh80000001;

  logic clk = 1'b0;
  logic rst_n;
  logic open_run = 1'b0;
  logic order_now = 1'b0;
  int   inputs_taken = 0;
  int   cycles = 0;
  int   fail_total;
  int   due_count;

  always #2 clk = ~clk;

  irsc_in_if  in_ch ();
  irsc_out_if out_ch ();
  irsc_cfg_if cfg_ch ();

  int_range_sortcheck_compact_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  irsc_stream_watch watch (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_sample         (in_ch.sample),
    .in_final          (in_ch.final_item),
    .cfg_valid         (cfg_ch.valid),
    .cfg_ready         (cfg_ch.ready),
    .cfg_descending    (cfg_ch.descending_order),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_kind          (out_ch.kind),
    .out_kept_value    (out_ch.kept_value),
    .out_min_value     (out_ch.min_value),
    .out_max_value     (out_ch.max_value),
    .out_missing_count (out_ch.missing_count),
    .out_out_of_order  (out_ch.out_of_order),
    .out_run_end       (out_ch.run_end),
    .fail_total        (fail_total),
    .due_count         (due_count)
  );

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) inputs_taken <= inputs_taken + 1;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (open_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t any_sample();
    case ($urandom_range(0, 9))
      0: return MISS_MARK;
      1: return TOP_VAL;
      2: return LOW_VAL;
      3: return $urandom_range(0, 1) ? sample_t'(0) : sample_t'(-1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // next value of a run in the given order, equal steps common, clamped to the kept range
  function automatic sample_t next_sorted(input sample_t prev, input logic down);
    longint v;
    longint step;
    step = ($urandom_range(0, 3) == 0) ? longint'($urandom) : longint'($urandom_range(0, 20));
    v = down ? longint'(prev) - step : longint'(prev) + step;
    if (v > longint'(TOP_VAL)) v = longint'(TOP_VAL);
    if (v < longint'(LOW_VAL)) v = longint'(LOW_VAL);
    return sample_t'(v);
  endfunction

  task automatic offer_sample(input sample_t s, input logic fin);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= s;
    in_ch.final_item <= fin;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // lets every queued result drain, then the block's latency
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_order(input logic down);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.descending_order <= down;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    order_now = down;
  endtask

  // one stream: tidy runs follow the given order with a rare stray value
  task automatic play_stream(input int len, input logic down, input logic tidy,
                             input logic close);
    sample_t cur;
    sample_t s;
    int unsigned miss_pct;
    miss_pct = ($urandom_range(0, 3) == 0) ? 60 : 10;
    cur = any_sample();
    if (cur == MISS_MARK) cur = sample_t'(0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < miss_pct) s = MISS_MARK;
      else if (tidy && $urandom_range(0, 24) != 0) begin
        s   = cur;
        cur = next_sorted(cur, down);
      end else s = any_sample();
      offer_sample(s, close && (i == len - 1));
    end
  endtask

  // receiver: random stalls, and once a long hold-off while the sender keeps going
  initial begin
    int unsigned n;
    logic held_once;
    held_once = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_once && inputs_taken >= 500) begin
        held_once = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        n = pick_gap();
        if (n != 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL int_range_sortcheck_compact_top");
    $finish;
  end

  initial begin
    int   sent;
    int   len;
    logic tidy;
    logic down;
    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.sample            <= '0;
    in_ch.final_item        <= 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.descending_order <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ascending after reset: equal pair, missing entry, extremes, order broken by the low extreme
    offer_sample(sample_t'(5), 1'b0);
    offer_sample(sample_t'(5), 1'b0);
    offer_sample(sample_t'(7), 1'b0);
    offer_sample(MISS_MARK, 1'b0);
    offer_sample(LOW_VAL, 1'b0);
    offer_sample(TOP_VAL, 1'b1);
    // stream of missing entries only, closed by a missing one
    offer_sample(MISS_MARK, 1'b0);
    offer_sample(MISS_MARK, 1'b1);
    // single kept value closing its stream
    offer_sample(sample_t'(0), 1'b1);
    // sorted ascending, closed by the top value
    offer_sample(sample_t'(-1), 1'b0);
    offer_sample(sample_t'(0), 1'b0);
    offer_sample(sample_t'(1), 1'b0);
    offer_sample(MISS_MARK, 1'b0);
    offer_sample(TOP_VAL, 1'b1);
    settle();
    set_order(1'b1);
    offer_sample(TOP_VAL, 1'b0);
    offer_sample(sample_t'(100), 1'b0);
    offer_sample(sample_t'(100), 1'b0);
    offer_sample(LOW_VAL, 1'b1);
    offer_sample(sample_t'(3), 1'b0);
    offer_sample(sample_t'(4), 1'b1);
    // order flipped in the middle of a stream
    offer_sample(sample_t'(20), 1'b0);
    offer_sample(sample_t'(10), 1'b0);
    settle();
    set_order(1'b0);
    offer_sample(sample_t'(15), 1'b0);
    offer_sample(sample_t'(30), 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      set_order(ph < 4 ? ph[0] : logic'($urandom_range(0, 1)));
      open_run = (ph == 2);
      sent = 0;
      while (sent < 225) begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        tidy = ($urandom_range(0, 99) < 75);
        down = tidy ? order_now : logic'($urandom_range(0, 1));
        play_stream(len, down, tidy, $urandom_range(0, 19) != 0);
        sent += len;
      end
      open_run = 1'b0;
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_total == 0) begin
      $display("PASS int_range_sortcheck_compact_top");
    end else begin
      $display("FAIL int_range_sortcheck_compact_top");
    end
    $finish;
  end

endmodule
